// ===== design/sse_pkg.sv =====
// sse_pkg: command and status codes and fixed field widths of the sparse set engine.
// Depends on nothing; used by sparse_set_engine.
package sse_pkg;

    localparam int CMD_W    = 3;
    localparam int VERTEX_W = 9;
    localparam int POS_W    = 8;
    localparam int SIZE_W   = 9;
    localparam int STATUS_W = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_REMOVE = 3'd1,
        CMD_QUERY  = 3'd2,
        CMD_GET    = 3'd3,
        CMD_CLEAR  = 3'd4
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2,
        ST_RANGE   = 2'd3
    } t_status;

endpackage

// ===== design/sparse_set_engine.sv =====
// sparse_set_engine: sparse set of vertex numbers with a dense member list and a slot store.
// Depends on sse_pkg (codes, widths) and sse_ram (dense list copies, slot store).
//
//   channel | valid        | stall        | payload
//   --------+--------------+--------------+-------------------------------------------
//   in      | i_in_valid   | o_in_stall   | i_cmd, i_vertex, i_position
//   out     | o_out_valid  | i_out_stall  | o_is_member, o_member, o_size, o_status
//
// One command is accepted per cycle while o_in_stall is low, and its result reaches the
// output register after the slot store read, then the dense list read at that slot.
// Writes of the command in the decide stage are forwarded to the two commands behind it.
// Reset clears the member count, valids and forwarding enables; the stores are not cleared.
// A stalled result freezes the whole pipeline, so o_in_stall follows i_out_stall then.
module sparse_set_engine #(
    parameter int MAX_VERTICES = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sse_pkg::CMD_W-1:0]     i_cmd,
    input  logic [sse_pkg::VERTEX_W-1:0]  i_vertex,
    input  logic [sse_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_is_member,
    output logic [sse_pkg::VERTEX_W-1:0]  o_member,
    output logic [sse_pkg::SIZE_W-1:0]    o_size,
    output logic [sse_pkg::STATUS_W-1:0]  o_status
);

    localparam int VW = sse_pkg::VERTEX_W;
    localparam int AW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int XW = (CW > VW) ? CW : VW;

    logic advance;

    // Stage 1: command registered, slot store data arriving.
    logic                   r_s1_valid;
    sse_pkg::t_cmd          r_s1_cmd;
    logic [VW-1:0]          r_s1_vertex;
    logic [sse_pkg::POS_W-1:0] r_s1_pos;

    // Stage 2: dense list data arriving, decision and store writes.
    logic                   r_s2_valid;
    sse_pkg::t_cmd          r_s2_cmd;
    logic [VW-1:0]          r_s2_vertex;
    logic [sse_pkg::POS_W-1:0] r_s2_pos;
    logic [AW-1:0]          r_s2_slot;
    logic [AW-1:0]          r_s2_addra;
    logic [AW-1:0]          r_s2_addrb;

    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;

    // Writes made in the decide stage, kept for forwarding.
    logic                   r_fw_dense_we;
    logic [AW-1:0]          r_fw_dense_addr;
    logic [VW-1:0]          r_fw_dense_data;
    logic                   r_fw_slot_we;
    logic [AW-1:0]          r_fw_slot_addr;
    logic [AW-1:0]          r_fw_slot_data;

    logic                   w_dense_we;
    logic [AW-1:0]          w_dense_addr;
    logic [VW-1:0]          w_dense_data;
    logic                   w_slot_we;
    logic [AW-1:0]          w_slot_addr;
    logic [AW-1:0]          w_slot_data;

    logic [AW-1:0]          slot_rdata;
    logic [VW-1:0]          dense_a_rdata;
    logic [VW-1:0]          dense_b_rdata;

    logic [AW-1:0]          in_idx;
    logic [AW-1:0]          s1_idx;
    logic [AW-1:0]          s1_slot;
    logic [AW-1:0]          s1_addra;
    logic [AW-1:0]          s1_addrb;
    logic [CW-1:0]          count_m1;

    logic [VW-1:0]          dense_a;
    logic [VW-1:0]          last;
    logic                   vertex_ok;
    logic                   last_ok;
    logic                   present;
    logic                   is_mem;
    logic [VW-1:0]          member;
    sse_pkg::t_status       status;
    logic                   dense_wr;
    logic                   slot_wr;

    logic                   r_out_valid;
    logic                   r_out_is_member;
    logic [VW-1:0]          r_out_member;
    logic [sse_pkg::SIZE_W-1:0]   r_out_size;
    logic [sse_pkg::STATUS_W-1:0] r_out_status;

    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = !advance;

    assign in_idx = AW'(i_vertex - VW'(1));
    assign s1_idx = AW'(r_s1_vertex - VW'(1));

    // Slot seen by stage 1: newest write first, then the write made when it was read.
    always_comb begin
        if (w_slot_we && (w_slot_addr == s1_idx)) begin
            s1_slot = w_slot_data;
        end else if (r_fw_slot_we && (r_fw_slot_addr == s1_idx)) begin
            s1_slot = r_fw_slot_data;
        end else begin
            s1_slot = slot_rdata;
        end
    end

    assign s1_addra = (r_s1_cmd == sse_pkg::CMD_GET) ? AW'(r_s1_pos) : s1_slot;
    assign count_m1 = n_count - CW'(1);
    assign s1_addrb = AW'(count_m1);

    // The dense reads missed only the write made at the same edge.
    assign dense_a = (r_fw_dense_we && (r_fw_dense_addr == r_s2_addra)) ?
                     r_fw_dense_data : dense_a_rdata;
    assign last    = (r_fw_dense_we && (r_fw_dense_addr == r_s2_addrb)) ?
                     r_fw_dense_data : dense_b_rdata;

    assign vertex_ok = (r_s2_vertex != '0) && (XW'(r_s2_vertex) <= XW'(MAX_VERTICES));
    assign last_ok   = (last != '0) && (XW'(last) <= XW'(MAX_VERTICES));
    assign present   = (XW'(r_s2_slot) < XW'(r_count)) && (dense_a == r_s2_vertex);

    always_comb begin
        n_count      = r_count;
        is_mem       = 1'b0;
        member       = '0;
        status       = sse_pkg::ST_OK;
        dense_wr     = 1'b0;
        slot_wr      = 1'b0;
        w_dense_addr = AW'(r_count);
        w_dense_data = r_s2_vertex;
        w_slot_addr  = AW'(r_s2_vertex - VW'(1));
        w_slot_data  = AW'(r_count);
        if (r_s2_valid) begin
            unique case (r_s2_cmd)
                sse_pkg::CMD_ADD: begin
                    if (!vertex_ok) begin
                        status = sse_pkg::ST_RANGE;
                    end else if (present) begin
                        status = sse_pkg::ST_PRESENT;
                    end else if (r_count == CW'(MAX_VERTICES)) begin
                        status = sse_pkg::ST_RANGE;
                    end else begin
                        dense_wr = 1'b1;
                        slot_wr  = 1'b1;
                        n_count  = r_count + CW'(1);
                    end
                end
                sse_pkg::CMD_REMOVE: begin
                    if (!vertex_ok) begin
                        status = sse_pkg::ST_RANGE;
                    end else if (!present) begin
                        status = sse_pkg::ST_ABSENT;
                    end else begin
                        // The last member moves into the freed slot.
                        n_count      = r_count - CW'(1);
                        dense_wr     = 1'b1;
                        w_dense_addr = r_s2_slot;
                        w_dense_data = last;
                        slot_wr      = last_ok;
                        w_slot_addr  = AW'(last - VW'(1));
                        w_slot_data  = r_s2_slot;
                    end
                end
                sse_pkg::CMD_QUERY: begin
                    if (!vertex_ok) begin
                        status = sse_pkg::ST_RANGE;
                    end else begin
                        is_mem = present;
                    end
                end
                sse_pkg::CMD_GET: begin
                    if (XW'(r_s2_pos) < XW'(r_count)) begin
                        member = dense_a;
                    end else begin
                        status = sse_pkg::ST_RANGE;
                    end
                end
                sse_pkg::CMD_CLEAR: begin
                    n_count = '0;
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    assign w_dense_we = advance && dense_wr;
    assign w_slot_we  = advance && slot_wr;

    sse_ram #(
        .WIDTH (AW),
        .DEPTH (MAX_VERTICES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_slot_we),
        .i_waddr (w_slot_addr),
        .i_wdata (w_slot_data),
        .i_re    (advance),
        .i_raddr (in_idx),
        .o_rdata (slot_rdata)
    );

    // Two copies of the dense list, written together, give two read ports.
    sse_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_dense_a_ram (
        .i_clk   (i_clk),
        .i_we    (w_dense_we),
        .i_waddr (w_dense_addr),
        .i_wdata (w_dense_data),
        .i_re    (advance),
        .i_raddr (s1_addra),
        .o_rdata (dense_a_rdata)
    );

    sse_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_VERTICES)
    ) u_dense_b_ram (
        .i_clk   (i_clk),
        .i_we    (w_dense_we),
        .i_waddr (w_dense_addr),
        .i_wdata (w_dense_data),
        .i_re    (advance),
        .i_raddr (s1_addrb),
        .o_rdata (dense_b_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_count       <= '0;
            r_fw_dense_we <= 1'b0;
            r_fw_slot_we  <= 1'b0;
        end else if (advance) begin
            r_s1_valid    <= i_in_valid;
            r_s2_valid    <= r_s1_valid;
            r_out_valid   <= r_s2_valid;
            r_count       <= n_count;
            r_fw_dense_we <= w_dense_we;
            r_fw_slot_we  <= w_slot_we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_cmd        <= sse_pkg::t_cmd'(i_cmd);
            r_s1_vertex     <= i_vertex;
            r_s1_pos        <= i_position;
            r_s2_cmd        <= r_s1_cmd;
            r_s2_vertex     <= r_s1_vertex;
            r_s2_pos        <= r_s1_pos;
            r_s2_slot       <= s1_slot;
            r_s2_addra      <= s1_addra;
            r_s2_addrb      <= s1_addrb;
            r_fw_dense_addr <= w_dense_addr;
            r_fw_dense_data <= w_dense_data;
            r_fw_slot_addr  <= w_slot_addr;
            r_fw_slot_data  <= w_slot_data;
            r_out_is_member <= is_mem;
            r_out_member    <= member;
            r_out_size      <= sse_pkg::SIZE_W'(n_count);
            r_out_status    <= status;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_is_member = r_out_is_member;
    assign o_member    = r_out_member;
    assign o_size      = r_out_size;
    assign o_status    = r_out_status;

endmodule

// ===== design/sse_ram.sv =====
// sse_ram: generic single-write, single-read RAM with a registered read port.
// A read and a write to the same address in one cycle return the old data.
// No dependencies.
module sse_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== dv/sparse_set_engine_tb.sv =====
// sparse_set_engine_tb: self-checking testbench for the sparse set engine, with directed and
// random command streams, random idling on both channels and a long output hold-off.
// Depends on sse_pkg (codes, widths) and the sparse_set_engine RTL.
module sparse_set_engine_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_VERTICES = 256;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int GAP_MAX      = 11;
    localparam int RANDOM_ITEMS = 1100;
    localparam int HOLD_AFTER   = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [sse_pkg::CMD_W-1:0]    cmd;
        logic [sse_pkg::VERTEX_W-1:0] vertex;
        logic [sse_pkg::POS_W-1:0]    position;
    } t_command;

    typedef struct packed {
        logic                         is_member;
        logic [sse_pkg::VERTEX_W-1:0] member;
        logic [sse_pkg::SIZE_W-1:0]   size;
        sse_pkg::t_status             status;
    } t_outcome;

    typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_NOISE} t_mix;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic [sse_pkg::CMD_W-1:0]     i_cmd = '0;
    logic [sse_pkg::VERTEX_W-1:0]  i_vertex = '0;
    logic [sse_pkg::POS_W-1:0]     i_position = '0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_is_member;
    logic [sse_pkg::VERTEX_W-1:0]  o_member;
    logic [sse_pkg::SIZE_W-1:0]    o_size;
    logic [sse_pkg::STATUS_W-1:0]  o_status;

    sparse_set_engine #(
        .MAX_VERTICES(NUM_VERTICES)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_cmd      (i_cmd),
        .i_vertex   (i_vertex),
        .i_position (i_position),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_is_member(o_is_member),
        .o_member   (o_member),
        .o_size     (o_size),
        .o_status   (o_status)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Commands waiting to be sent and results waiting to be seen.
    t_command pending_commands[$];
    t_outcome expected_results[$];

    // Predicted set contents, updated on every accepted command.
    logic [sse_pkg::VERTEX_W-1:0] set_list [NUM_VERTICES];
    logic [sse_pkg::POS_W-1:0]    set_slot [NUM_VERTICES];
    int                           set_count = 0;

    // Shadow membership used only to shape the stimulus.
    bit gen_member  [1:NUM_VERTICES];
    int gen_count = 0;

    int       mismatch_count = 0;
    int       results_seen = 0;
    int       cycle_count = 0;
    logic     in_taken = 1'b0;
    logic     out_taken = 1'b0;
    int       send_wait = 0;
    bit       send_quiet = 1'b0;
    int       recv_wait = 0;
    bit       recv_quiet = 1'b0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    t_command next_command;
    t_command seen_command;
    t_outcome want;

    function automatic t_outcome apply_command(t_command c);
        t_outcome                     r;
        int                           idx;
        int                           s;
        logic                         present;
        logic [sse_pkg::VERTEX_W-1:0] last;
        r = '0;
        case (sse_pkg::t_cmd'(c.cmd)) inside
            sse_pkg::CMD_ADD, sse_pkg::CMD_REMOVE, sse_pkg::CMD_QUERY: begin
                if (c.vertex == 0 || c.vertex > NUM_VERTICES) begin
                    r.status = sse_pkg::ST_RANGE;
                end else begin
                    idx = int'(c.vertex) - 1;
                    s = int'(set_slot[idx]);
                    // Stale slot entries are harmless: the list must point back.
                    present = (s < set_count) && (set_list[s] == c.vertex);
                    if (c.cmd == sse_pkg::CMD_ADD) begin
                        if (present) begin
                            r.status = sse_pkg::ST_PRESENT;
                        end else if (set_count >= NUM_VERTICES) begin
                            r.status = sse_pkg::ST_RANGE;
                        end else begin
                            set_list[set_count] = c.vertex;
                            set_slot[idx] = sse_pkg::POS_W'(set_count);
                            set_count++;
                        end
                    end else if (c.cmd == sse_pkg::CMD_REMOVE) begin
                        if (!present) begin
                            r.status = sse_pkg::ST_ABSENT;
                        end else begin
                            // The last member fills the freed slot.
                            last = set_list[set_count - 1];
                            set_count--;
                            set_list[s] = last;
                            if (last >= 1 && last <= NUM_VERTICES)
                                set_slot[int'(last) - 1] = sse_pkg::POS_W'(s);
                        end
                    end else begin
                        r.is_member = present;
                    end
                end
            end
            sse_pkg::CMD_GET: begin
                if (int'(c.position) < set_count)
                    r.member = set_list[c.position];
                else
                    r.status = sse_pkg::ST_RANGE;
            end
            sse_pkg::CMD_CLEAR: set_count = 0;
            default: ;
        endcase
        r.size = sse_pkg::SIZE_W'(set_count);
        return r;
    endfunction

    task automatic queue_command(input logic [sse_pkg::CMD_W-1:0] cmd,
                                 input logic [sse_pkg::VERTEX_W-1:0] v,
                                 input logic [sse_pkg::POS_W-1:0] p);
        t_command c;
        c.cmd = cmd;
        c.vertex = v;
        c.position = p;
        pending_commands.push_back(c);
        if (cmd == sse_pkg::CMD_ADD && v >= 1 && v <= NUM_VERTICES &&
            gen_count < NUM_VERTICES) begin
            if (!gen_member[v]) begin
                gen_member[v] = 1'b1;
                gen_count++;
            end
        end else if (cmd == sse_pkg::CMD_REMOVE && v >= 1 && v <= NUM_VERTICES &&
                     gen_member[v]) begin
            gen_member[v] = 1'b0;
            gen_count--;
        end else if (cmd == sse_pkg::CMD_CLEAR) begin
            foreach (gen_member[i]) gen_member[i] = 1'b0;
            gen_count = 0;
        end
    endtask

    function automatic int pick_member();
        int v;
        v = $urandom_range(1, NUM_VERTICES);
        while (!gen_member[v]) v = $urandom_range(1, NUM_VERTICES);
        return v;
    endfunction

    function automatic int pick_out_of_range();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(NUM_VERTICES + 1, (1 << sse_pkg::VERTEX_W) - 1);
    endfunction

    // Random traffic runs only once every vertex has been added at least once,
    // so every slot entry it can reach has been written.
    task automatic random_command(t_mix mix);
        int roll;
        int pick;
        int w_add;
        int w_rem;
        int w_qry;
        int w_get;
        int v;
        int p;
        if (mix == MIX_NOISE) begin
            queue_command(sse_pkg::CMD_W'($urandom_range(0, (1 << sse_pkg::CMD_W) - 1)),
                          sse_pkg::VERTEX_W'($urandom_range(0, (1 << sse_pkg::VERTEX_W) - 1)),
                          sse_pkg::POS_W'($urandom_range(0, (1 << sse_pkg::POS_W) - 1)));
            return;
        end
        case (mix)
            MIX_GROW: begin
                w_add = 65; w_rem = 10; w_qry = 10; w_get = 13;
            end
            MIX_SHRINK: begin
                w_add = 15; w_rem = 55; w_qry = 12; w_get = 16;
            end
            default: begin
                w_add = 35; w_rem = 30; w_qry = 15; w_get = 18;
            end
        endcase
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, 99);
        v = $urandom_range(1, NUM_VERTICES);
        p = $urandom_range(0, (1 << sse_pkg::POS_W) - 1);
        if (roll < w_add) begin
            if (pick < 5)
                v = pick_out_of_range();
            else if (pick < 15 && gen_count > 0)
                v = pick_member();
            queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(v), sse_pkg::POS_W'(p));
        end else if (roll < w_add + w_rem) begin
            if (pick < 5)
                v = pick_out_of_range();
            else if (pick < 80 && gen_count > 0)
                v = pick_member();
            queue_command(sse_pkg::CMD_REMOVE, sse_pkg::VERTEX_W'(v), sse_pkg::POS_W'(p));
        end else if (roll < w_add + w_rem + w_qry) begin
            if (pick < 5)
                v = pick_out_of_range();
            else if (pick < 55 && gen_count > 0)
                v = pick_member();
            queue_command(sse_pkg::CMD_QUERY, sse_pkg::VERTEX_W'(v), sse_pkg::POS_W'(p));
        end else if (roll < w_add + w_rem + w_qry + w_get) begin
            if (pick < 80 && gen_count > 0)
                p = $urandom_range(0, gen_count - 1);
            queue_command(sse_pkg::CMD_GET,
                          sse_pkg::VERTEX_W'($urandom_range(0, (1 << sse_pkg::VERTEX_W) - 1)),
                          sse_pkg::POS_W'(p));
        end else if (roll < 99) begin
            queue_command(sse_pkg::CMD_CLEAR, sse_pkg::VERTEX_W'(v), sse_pkg::POS_W'(p));
        end else begin
            queue_command(sse_pkg::CMD_W'($urandom_range(int'(sse_pkg::CMD_CLEAR) + 1,
                                                         (1 << sse_pkg::CMD_W) - 1)),
                          sse_pkg::VERTEX_W'($urandom_range(0, (1 << sse_pkg::VERTEX_W) - 1)),
                          sse_pkg::POS_W'(p));
        end
    endtask

    task automatic build_stimulus();
        int   order [NUM_VERTICES];
        int   j;
        int   tmp;
        int   made;
        int   burst;
        t_mix mix;
        // Before every vertex has been added, unused fields point at vertex 1
        // and slot 0, which the first command writes.
        queue_command(sse_pkg::CMD_ADD, 1, 0);
        queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_ADD, 1, 0);
        queue_command(sse_pkg::CMD_QUERY, 1, 0);
        queue_command(sse_pkg::CMD_QUERY, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_GET, 1, 0);
        queue_command(sse_pkg::CMD_GET, 1, 1);
        queue_command(sse_pkg::CMD_REMOVE, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_REMOVE, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_QUERY, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);
        queue_command(sse_pkg::CMD_ADD, 128, 0);
        queue_command(sse_pkg::CMD_REMOVE, 1, 0);
        queue_command(sse_pkg::CMD_GET, 1, 0);
        queue_command(sse_pkg::CMD_GET, 1, 1);
        queue_command(sse_pkg::CMD_GET, 1, 2);
        for (int c = int'(sse_pkg::CMD_CLEAR) + 1; c < (1 << sse_pkg::CMD_W); c++)
            queue_command(sse_pkg::CMD_W'(c), 1, 0);
        queue_command(sse_pkg::CMD_CLEAR, 1, 0);
        queue_command(sse_pkg::CMD_QUERY, 128, 0);
        queue_command(sse_pkg::CMD_GET, 1, 0);
        queue_command(sse_pkg::CMD_REMOVE, 128, 0);

        // Fill the set to capacity in a shuffled order.
        foreach (order[i]) order[i] = i + 1;
        for (int i = NUM_VERTICES - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        foreach (order[i])
            queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(order[i]), sse_pkg::POS_W'(i));

        queue_command(sse_pkg::CMD_GET, 0, sse_pkg::POS_W'((1 << sse_pkg::POS_W) - 1));
        queue_command(sse_pkg::CMD_GET, sse_pkg::VERTEX_W'((1 << sse_pkg::VERTEX_W) - 1), 0);
        queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(pick_member()), 0);
        queue_command(sse_pkg::CMD_ADD, 0, 0);
        queue_command(sse_pkg::CMD_ADD, sse_pkg::VERTEX_W'(NUM_VERTICES + 1), 0);
        queue_command(sse_pkg::CMD_QUERY, sse_pkg::VERTEX_W'((1 << sse_pkg::VERTEX_W) - 1), 0);
        queue_command(sse_pkg::CMD_REMOVE, 0, 0);
        queue_command(sse_pkg::CMD_REMOVE, sse_pkg::VERTEX_W'((1 << sse_pkg::VERTEX_W) - 1), 0);
        queue_command(sse_pkg::CMD_QUERY, sse_pkg::VERTEX_W'(NUM_VERTICES), 0);

        made = 0;
        while (made < RANDOM_ITEMS) begin
            tmp = $urandom_range(0, 9);
            mix = (tmp == 0) ? MIX_NOISE : (tmp < 4) ? MIX_GROW :
                  (tmp < 7) ? MIX_SHRINK : MIX_EVEN;
            burst = $urandom_range(20, 80);
            for (int k = 0; k < burst; k++) random_command(mix);
            made += burst;
        end
    endtask

    // Sender: a new command goes out once the previous one has transferred
    // and its drawn gap has elapsed.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                i_in_valid <= 1'b0;
            end else if (pending_commands.size() != 0) begin
                next_command = pending_commands.pop_front();
                i_cmd <= next_command.cmd;
                i_vertex <= next_command.vertex;
                i_position <= next_command.position;
                i_in_valid <= 1'b1;
                if ($urandom_range(0, 49) == 0)
                    send_quiet <= !send_quiet;
                send_wait <= send_quiet ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: a drawn stall after each result, and one long hold-off that
    // lets the pipeline fill and push back on the sender.
    always @(negedge i_clk) begin : receiver
        int draw;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (out_taken) begin
            if ($urandom_range(0, 49) == 0)
                recv_quiet <= !recv_quiet;
            draw = recv_quiet ? 0 : $urandom_range(0, GAP_MAX);
            i_out_stall <= (draw > 0);
            recv_wait <= (draw > 0) ? draw - 1 : 0;
        end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: results are checked before the command of the same edge is predicted.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && (o_in_stall === 1'b0);
        out_taken <= i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && !i_out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result transfer with no command outstanding");
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (o_is_member !== want.is_member) begin
                        $error("is_member: expected %0d, got %0d", want.is_member, o_is_member);
                        mismatch_count++;
                    end
                    if (o_member !== want.member) begin
                        $error("member: expected %0d, got %0d", want.member, o_member);
                        mismatch_count++;
                    end
                    if (o_size !== want.size) begin
                        $error("size: expected %0d, got %0d", want.size, o_size);
                        mismatch_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_stall === 1'b0) begin
                seen_command.cmd = i_cmd;
                seen_command.vertex = i_vertex;
                seen_command.position = i_position;
                expected_results.push_back(apply_command(seen_command));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sparse_set_engine verification failed");
            $finish;
        end
    end

    initial begin
        foreach (set_list[i]) begin
            set_list[i] = '0;
            set_slot[i] = '0;
        end
        build_stimulus();
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_commands.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("sparse_set_engine verification clean");
        else
            $display("sparse_set_engine verification failed");
        $finish;
    end

endmodule
